// ----- rtl/lspbe_pkg.sv -----
// Package for the LED strip pixel bit encoder.
// Holds the payload, configuration and internal control structs and the code constants.
// No dependencies.
`timescale 1ns / 1ps

package lspbe_pkg;

    // Bits sent for one pixel, and the width of a count that can hold that number.
    localparam int BITS_PER_PIXEL = 24;
    localparam int LEFT_W         = 5;

    // Item function codes.
    localparam logic [2:0] FUNC_SET   = 3'd0;
    localparam logic [2:0] FUNC_BLANK = 3'd1;
    localparam logic [2:0] FUNC_CLEAR = 3'd2;
    localparam logic [2:0] FUNC_SEND  = 3'd3;
    localparam logic [2:0] FUNC_END   = 3'd4;

    // Register indexes on the configuration port (byte address is four times the index).
    localparam logic [2:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [2:0] REG_ENABLED     = 3'd1;
    localparam logic [2:0] REG_PIXEL_COUNT = 3'd2;
    localparam logic [2:0] REG_ONE_CODE    = 3'd3;
    localparam logic [2:0] REG_ZERO_CODE   = 3'd4;

    // Input item.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [15:0] pwm_code;
        logic        last;
    } t_out_item;

    // Configuration register values.
    typedef struct packed {
        logic [7:0]  brightness;
        logic        enabled;
        logic [8:0]  pixel_count;
        logic [15:0] one_code;
        logic [15:0] zero_code;
    } t_cfg;

    // Request to the pixel store.
    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [7:0]  index;
        logic [23:0] color;
    } t_store_op;

    // Load request to the serialiser.
    typedef struct packed {
        logic        load;
        logic        frame_end;
        logic [23:0] word;
    } t_ser_load;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_CLEAR
    } t_state;

endpackage

// ----- rtl/lspbe_cfg.sv -----
// Configuration register bank of the LED strip pixel bit encoder, on an APB-style port.
// Depends on lspbe_pkg.
`timescale 1ns / 1ps

module lspbe_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output lspbe_pkg::t_cfg      o_cfg
);

    lspbe_pkg::t_cfg r_cfg;
    logic [2:0]      reg_idx;
    logic            wr_xfer;

    assign reg_idx = paddr[4:2];
    assign wr_xfer = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; an address beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness  <= 8'd255;
            r_cfg.enabled     <= 1'b1;
            r_cfg.pixel_count <= 9'd256;
            r_cfg.one_code    <= 16'd0;
            r_cfg.zero_code   <= 16'd0;
        end else if (wr_xfer) begin
            case (reg_idx)
                lspbe_pkg::REG_BRIGHTNESS:  r_cfg.brightness  <= pwdata[7:0];
                lspbe_pkg::REG_ENABLED:     r_cfg.enabled     <= pwdata[0];
                lspbe_pkg::REG_PIXEL_COUNT: r_cfg.pixel_count <= pwdata[8:0];
                lspbe_pkg::REG_ONE_CODE:    r_cfg.one_code    <= pwdata[15:0];
                lspbe_pkg::REG_ZERO_CODE:   r_cfg.zero_code   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        case (reg_idx)
            lspbe_pkg::REG_BRIGHTNESS:  prdata = {24'd0, r_cfg.brightness};
            lspbe_pkg::REG_ENABLED:     prdata = {31'd0, r_cfg.enabled};
            lspbe_pkg::REG_PIXEL_COUNT: prdata = {23'd0, r_cfg.pixel_count};
            lspbe_pkg::REG_ONE_CODE:    prdata = {16'd0, r_cfg.one_code};
            lspbe_pkg::REG_ZERO_CODE:   prdata = {16'd0, r_cfg.zero_code};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/lspbe_store.sv -----
// Pixel colour store: a synchronous memory with a registered read.
// Depends on lspbe_pkg.
`timescale 1ns / 1ps

module lspbe_store #(
    parameter int DEPTH = 256
) (
    input  logic                 i_clk,
    input  lspbe_pkg::t_store_op i_op,
    output logic [23:0]          o_rd_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [23:0]       mem [DEPTH];
    logic [23:0]       r_rd_data;
    logic [ADDR_W-1:0] addr;

    assign addr      = i_op.index[ADDR_W-1:0];
    assign o_rd_data = r_rd_data;

    // Memory array: colour write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            mem[addr] <= i_op.color;
        end
        if (i_op.rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

endmodule

// ----- rtl/lspbe_ser.sv -----
// Bit serialiser: turns a 24-bit GRB word into compare codes, MSB first, or sends one frame-end code.
// Drives the result channel from its own registers. Depends on lspbe_pkg.
`timescale 1ns / 1ps

module lspbe_ser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lspbe_pkg::t_ser_load  i_load,
    input  lspbe_pkg::t_cfg       i_cfg,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output lspbe_pkg::t_out_item  o_out_data,
    output logic                  o_ready
);

    logic [lspbe_pkg::LEFT_W-1:0] r_left;
    logic [23:0]                  r_word;
    logic                         r_frame_end;
    logic                         xfer;

    assign o_out_valid = (r_left != '0);
    assign xfer        = o_out_valid && !i_out_stall;
    assign o_ready     = (r_left == '0);

    // Codes still to send; a transfer moves on to the next bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load.load) begin
            r_left <= i_load.frame_end ? lspbe_pkg::LEFT_W'(1)
                                       : lspbe_pkg::LEFT_W'(lspbe_pkg::BITS_PER_PIXEL);
        end else if (xfer) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Bit word and frame-end flag.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_word      <= i_load.word;
            r_frame_end <= i_load.frame_end;
        end else if (xfer) begin
            r_word <= {r_word[22:0], 1'b0};
        end
    end

    // Code for the bit at the head of the word.
    always_comb begin
        if (r_frame_end) begin
            o_out_data.pwm_code = 16'd0;
        end else if (r_word[23]) begin
            o_out_data.pwm_code = i_cfg.one_code;
        end else begin
            o_out_data.pwm_code = i_cfg.zero_code;
        end
        o_out_data.last = (r_left == lspbe_pkg::LEFT_W'(1));
    end

endmodule

// ----- rtl/led_strip_pixel_bit_encoder.sv -----
// Top level of the LED strip pixel bit encoder: item controller, pixel store,
// configuration registers and bit serialiser. Depends on lspbe_pkg, lspbe_cfg,
// lspbe_store and lspbe_ser.
//
// Items arrive on i_in_valid / i_in_data and are refused while o_in_stall is high.
// Set and blank write the pixel store at the edge of the transfer and give no result.
// Clear-all writes black to one pixel per cycle over the active count, stalling the
// input for the whole pass, and gives no result. Send pixel reads the store, scales
// the channels by the brightness and hands the GRB word to the serialiser once it is
// empty: the store read, the scaled word and the serialiser load are registered in turn
// before the first compare code is valid. End frame waits in S_LOAD for the serialiser
// and gives a single zero code from it. Results leave on o_out_valid / o_out_data, one
// code per transfer, last set on the final one. The serialiser gives one code per cycle
// while the receiver does not stall; other items are taken while codes stream out, but
// a new send or end frame waits until the serialiser is empty. When the receiver
// stalls, the current code is held unchanged and the serialiser waits. Reset loads the
// register defaults and then clears the store with a pass of one pixel per cycle,
// during which the input is stalled.
`timescale 1ns / 1ps

module led_strip_pixel_bit_encoder #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lspbe_pkg::t_in_item  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output lspbe_pkg::t_out_item o_out_data,
    input  logic                 i_out_stall,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Only the first 256 pixels can be addressed by an item.
    localparam int DEPTH = (MAX_PIXELS < 256) ? MAX_PIXELS : 256;

    lspbe_pkg::t_cfg       cfg;
    lspbe_pkg::t_store_op  st_op;
    lspbe_pkg::t_ser_load  ser_load;
    logic [23:0]           st_rd_data;
    logic                  ser_ready;

    lspbe_pkg::t_state     r_state, n_state;
    logic                  r_active, n_active;
    logic                  r_frame_end, n_frame_end;
    logic [23:0]           r_word, n_word;
    logic [7:0]            r_clr_idx, n_clr_idx;
    logic [7:0]            r_clr_last, n_clr_last;

    logic                  accept;
    logic                  idx_active;
    logic [23:0]           scaled;
    logic [8:0]            clr_count;
    logic [8:0]            clr_last;

    // Scale one channel by brightness / 255, rounding down.
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] p;
        logic [16:0] q;
        p = c * b;
        q = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return q[15:8];
    endfunction

    lspbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lspbe_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_op      (st_op),
        .o_rd_data (st_rd_data)
    );

    lspbe_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (ser_load),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_ready     (ser_ready)
    );

    // Items are taken only while the controller is idle.
    assign o_in_stall = (r_state != lspbe_pkg::S_IDLE);
    assign accept     = i_in_valid && (r_state == lspbe_pkg::S_IDLE);
    assign idx_active = ({1'b0, i_in_data.pixel_index} < cfg.pixel_count)
                        && (int'(i_in_data.pixel_index) < MAX_PIXELS);

    // Number of pixels that a clear-all blanks, and the last index of that pass.
    assign clr_count = (cfg.pixel_count < 9'(DEPTH)) ? cfg.pixel_count : 9'(DEPTH);
    assign clr_last  = clr_count - 9'd1;

    // Scaled colour of the pixel just read; black when off or out of range.
    always_comb begin
        if (r_active && cfg.enabled) begin
            scaled = {scale_chan(st_rd_data[23:16], cfg.brightness),
                      scale_chan(st_rd_data[15:8],  cfg.brightness),
                      scale_chan(st_rd_data[7:0],   cfg.brightness)};
        end else begin
            scaled = 24'd0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lspbe_pkg::S_IDLE: begin
                if (accept && (i_in_data.func == lspbe_pkg::FUNC_SEND)) begin
                    n_state = lspbe_pkg::S_READ;
                end else if (accept && (i_in_data.func == lspbe_pkg::FUNC_END)) begin
                    n_state = lspbe_pkg::S_LOAD;
                end else if (accept && (i_in_data.func == lspbe_pkg::FUNC_CLEAR)
                             && (clr_count != 9'd0)) begin
                    n_state = lspbe_pkg::S_CLEAR;
                end
            end
            lspbe_pkg::S_READ: n_state = lspbe_pkg::S_LOAD;
            lspbe_pkg::S_LOAD: begin
                if (ser_ready) begin
                    n_state = lspbe_pkg::S_IDLE;
                end
            end
            lspbe_pkg::S_CLEAR: begin
                if (r_clr_idx == r_clr_last) begin
                    n_state = lspbe_pkg::S_IDLE;
                end
            end
            default: n_state = lspbe_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath registers of each state.
    always_comb begin
        st_op.wr_en   = 1'b0;
        st_op.rd_en   = 1'b0;
        st_op.index   = i_in_data.pixel_index;
        st_op.color   = {i_in_data.green, i_in_data.red, i_in_data.blue};
        ser_load.load      = 1'b0;
        ser_load.frame_end = r_frame_end;
        ser_load.word      = r_word;
        n_active    = r_active;
        n_frame_end = r_frame_end;
        n_word      = r_word;
        n_clr_idx   = r_clr_idx;
        n_clr_last  = r_clr_last;
        case (r_state)
            lspbe_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in_data.func)
                        lspbe_pkg::FUNC_SET:   st_op.wr_en = idx_active;
                        lspbe_pkg::FUNC_BLANK: begin
                            st_op.wr_en = idx_active;
                            st_op.color = 24'd0;
                        end
                        lspbe_pkg::FUNC_CLEAR: begin
                            n_clr_idx  = 8'd0;
                            n_clr_last = clr_last[7:0];
                        end
                        lspbe_pkg::FUNC_SEND: begin
                            st_op.rd_en = 1'b1;
                            n_active    = idx_active;
                            n_frame_end = 1'b0;
                        end
                        lspbe_pkg::FUNC_END: begin
                            n_frame_end = 1'b1;
                            n_word      = 24'd0;
                        end
                        default: ;
                    endcase
                end
            end
            lspbe_pkg::S_READ: n_word = scaled;
            lspbe_pkg::S_LOAD: ser_load.load = ser_ready;
            lspbe_pkg::S_CLEAR: begin
                // One pixel written black per cycle.
                st_op.wr_en = 1'b1;
                st_op.index = r_clr_idx;
                st_op.color = 24'd0;
                n_clr_idx   = r_clr_idx + 8'd1;
            end
            default: ;
        endcase
    end

    // Controller state; reset starts a clearing pass over the whole store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lspbe_pkg::S_CLEAR;
            r_clr_idx  <= 8'd0;
            r_clr_last <= 8'(DEPTH - 1);
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_clr_last <= n_clr_last;
        end
    end

    // Item context held while a send or frame end is in progress.
    always_ff @(posedge i_clk) begin
        r_active    <= n_active;
        r_frame_end <= n_frame_end;
        r_word      <= n_word;
    end

endmodule

// ----- verif/pixel_code_monitor.sv -----
// Checking side of the LED strip pixel bit encoder testbench: predicts the compare codes
// for every accepted item and compares them with the codes that leave the block.
// Depends on lspbe_pkg.
`timescale 1ns / 1ps

module pixel_code_monitor #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lspbe_pkg::t_in_item  i_in_data,
    input  logic                 i_in_stall,
    input  logic                 i_out_valid,
    input  lspbe_pkg::t_out_item i_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [4:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    output int                   o_mismatches,
    output int                   o_pending
);

    // Shadow copy of the pixel store and of the configuration registers.
    logic [23:0] pixel_color [MAX_PIXELS];
    logic [7:0]  brightness;
    logic        enabled;
    logic [8:0]  pixel_count;
    logic [15:0] one_code;
    logic [15:0] zero_code;

    // Compare codes still to come out of the block, oldest first.
    lspbe_pkg::t_out_item code_queue [$];
    int                   mismatches;

    // One colour channel after the brightness scale, or black when the strip is off.
    function automatic logic [7:0] scale_level(input logic [7:0] level);
        logic [15:0] product;
        if (!enabled) begin
            return 8'd0;
        end
        product = level * brightness;
        return 8'(product / 16'd255);
    endfunction

    // Apply one item to the shadow store and queue the codes that it gives.
    task automatic encode_item(input lspbe_pkg::t_in_item item);
        int                   active;
        logic                 hit;
        logic [23:0]          grb;
        logic [23:0]          stored;
        lspbe_pkg::t_out_item code;
        active = (pixel_count < MAX_PIXELS) ? int'(pixel_count) : MAX_PIXELS;
        hit    = int'(item.pixel_index) < active;
        case (item.func)
            lspbe_pkg::FUNC_SET: begin
                if (hit) begin
                    pixel_color[item.pixel_index] = {item.green, item.red, item.blue};
                end
            end
            lspbe_pkg::FUNC_BLANK: begin
                if (hit) begin
                    pixel_color[item.pixel_index] = '0;
                end
            end
            lspbe_pkg::FUNC_CLEAR: begin
                for (int k = 0; k < active; k++) begin
                    pixel_color[k] = '0;
                end
            end
            lspbe_pkg::FUNC_SEND: begin
                grb = '0;
                if (hit) begin
                    stored = pixel_color[item.pixel_index];
                    grb = {scale_level(stored[23:16]), scale_level(stored[15:8]),
                           scale_level(stored[7:0])};
                end
                // Green first, most significant bit first.
                for (int k = 23; k >= 0; k--) begin
                    code.pwm_code = grb[k] ? one_code : zero_code;
                    code.last     = (k == 0);
                    code_queue.push_back(code);
                end
            end
            lspbe_pkg::FUNC_END: begin
                code.pwm_code = '0;
                code.last     = 1'b1;
                code_queue.push_back(code);
            end
            default: begin
            end
        endcase
    endtask

    // Follow register writes, check each code transfer, then predict each item transfer.
    always @(posedge i_clk) begin
        lspbe_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXELS; k++) begin
                pixel_color[k] = '0;
            end
            brightness  = 8'd255;
            enabled     = 1'b1;
            pixel_count = 9'd256;
            one_code    = '0;
            zero_code   = '0;
            code_queue.delete();
            mismatches  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    lspbe_pkg::REG_BRIGHTNESS:  brightness  = i_pwdata[7:0];
                    lspbe_pkg::REG_ENABLED:     enabled     = i_pwdata[0];
                    lspbe_pkg::REG_PIXEL_COUNT: pixel_count = i_pwdata[8:0];
                    lspbe_pkg::REG_ONE_CODE:    one_code    = i_pwdata[15:0];
                    lspbe_pkg::REG_ZERO_CODE:   zero_code   = i_pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (code_queue.size() == 0) begin
                    $error("unexpected code transfer: pwm_code %0d, last %0b",
                           i_out_data.pwm_code, i_out_data.last);
                    mismatches++;
                end else begin
                    want = code_queue.pop_front();
                    if (i_out_data.pwm_code !== want.pwm_code) begin
                        $error("pwm_code: expected %0d, actual %0d",
                               want.pwm_code, i_out_data.pwm_code);
                        mismatches++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_out_data.last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                encode_item(i_in_data);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= code_queue.size();
    end

endmodule

// ----- verif/tb.sv -----
// Top of the LED strip pixel bit encoder testbench: clock, reset, register writes,
// item stimulus with random gaps and receiver stalls, and the final verdict.
// Depends on lspbe_pkg, led_strip_pixel_bit_encoder and pixel_code_monitor.
`timescale 1ns / 1ps

module tb;

    // Function codes that the block must ignore.
    localparam logic [2:0] FUNC_SPARE_A = 3'd5;
    localparam logic [2:0] FUNC_SPARE_C = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    lspbe_pkg::t_in_item  in_data;
    logic                 in_stall;
    logic                 out_valid;
    lspbe_pkg::t_out_item out_data;
    logic                 out_stall;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [4:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   mismatches;
    int                   pending;

    // Idling odds in percent for the sender and the receiver, and the active count in use.
    int          in_gap_pct;
    int          out_stall_pct;
    int          cur_count;

    led_strip_pixel_bit_encoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pixel_code_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Safety net in case the block hangs.
    initial begin
        #1_200_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver stalls in random bursts.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic lspbe_pkg::t_in_item make_item(input logic [2:0] func,
                                                      input logic [7:0] index,
                                                      input logic [7:0] red,
                                                      input logic [7:0] green,
                                                      input logic [7:0] blue);
        lspbe_pkg::t_in_item item;
        item.func        = func;
        item.pixel_index = index;
        item.red         = red;
        item.green       = green;
        item.blue        = blue;
        return item;
    endfunction

    // Mostly a pixel near the bottom of the active range, sometimes anywhere.
    function automatic logic [7:0] pick_index(input int count);
        int hot;
        if (count == 0 || $urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        hot = (count > 32) ? 32 : count;
        return 8'($urandom_range(0, hot - 1));
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item, perhaps after a gap, and return at the edge of its transfer.
    task automatic push_item(input lspbe_pkg::t_in_item item);
        logic go;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end while (!go);
    endtask

    // Stop sending, wait until every code has arrived and the block is idle, then
    // let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0 || in_stall);
        repeat (8) @(posedge clk);
    endtask

    // Stimulus.
    initial begin
        lspbe_pkg::t_in_item item;
        int          sel;
        int          n;
        logic [7:0]  level;
        logic        on;
        logic [8:0]  count;
        logic [15:0] code_one;
        logic [15:0] code_zero;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        cur_count     = 256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: both codes are zero, so a send gives all-zero codes.
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd0, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_END, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        settle();

        // Full brightness with the code extremes; set, blank, clear and ignored codes.
        write_reg(lspbe_pkg::REG_ONE_CODE, 32'h0000_FFFF);
        write_reg(lspbe_pkg::REG_ZERO_CODE, 32'h0000_0000);
        in_gap_pct    = 30;
        out_stall_pct = 20;
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd0, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd255, 8'h12, 8'hA5, 8'h5A));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd255, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd1, 8'h80, 8'h01, 8'hFE));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd1, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_BLANK, 8'd255, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd255, 8'h00, 8'h00, 8'h00));
        push_item(make_item(FUNC_SPARE_A, 8'd1, 8'hAA, 8'h55, 8'hAA));
        push_item(make_item(FUNC_SPARE_C, 8'd2, 8'h55, 8'hAA, 8'h55));
        push_item(make_item(lspbe_pkg::FUNC_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd0, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd200, 8'h11, 8'h22, 8'h33));
        push_item(make_item(lspbe_pkg::FUNC_END, 8'd0, 8'h00, 8'h00, 8'h00));
        settle();

        // Short strip: writes and sends past the active count, and a clear that spares them.
        write_reg(lspbe_pkg::REG_BRIGHTNESS, 32'd128);
        write_reg(lspbe_pkg::REG_ONE_CODE, 32'h0000_0001);
        write_reg(lspbe_pkg::REG_ZERO_CODE, 32'h0000_FFFE);
        write_reg(lspbe_pkg::REG_PIXEL_COUNT, 32'd10);
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd9, 8'hC3, 8'h3C, 8'h99));
        push_item(make_item(lspbe_pkg::FUNC_SET, 8'd10, 8'hFF, 8'hFF, 8'hFF));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd9, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd200, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00));
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd9, 8'h00, 8'h00, 8'h00));
        settle();

        // Full strip again: the pixel past the old count kept its colour; then strip off.
        write_reg(lspbe_pkg::REG_PIXEL_COUNT, 32'd256);
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd200, 8'h00, 8'h00, 8'h00));
        settle();
        write_reg(lspbe_pkg::REG_ENABLED, 32'd0);
        push_item(make_item(lspbe_pkg::FUNC_SEND, 8'd200, 8'h00, 8'h00, 8'h00));

        // Random phases, each with its own settings; the last one runs without idling.
        for (int p = 0; p < 6; p++) begin
            settle();
            code_one  = 16'($urandom);
            code_zero = 16'($urandom);
            case (p)
                0: begin
                    level = 8'd255;
                    on    = 1'b1;
                    count = 9'd24;
                    in_gap_pct    = 30;
                    out_stall_pct = 20;
                end
                1: begin
                    level     = 8'd0;
                    on        = 1'b1;
                    count     = 9'd256;
                    code_one  = 16'h0000;
                    code_zero = 16'hFFFF;
                    in_gap_pct    = 0;
                    out_stall_pct = 30;
                end
                2: begin
                    level = 8'd1;
                    on    = 1'b1;
                    count = 9'd1;
                    in_gap_pct    = 15;
                    out_stall_pct = 0;
                end
                3: begin
                    level = 8'd128;
                    on    = 1'b0;
                    count = 9'd511;
                    in_gap_pct    = 40;
                    out_stall_pct = 10;
                end
                4: begin
                    level = 8'($urandom);
                    on    = 1'b1;
                    count = 9'd0;
                    in_gap_pct    = 20;
                    out_stall_pct = 40;
                end
                default: begin
                    level = 8'd254;
                    on    = 1'b1;
                    count = 9'($urandom_range(2, 64));
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
            endcase
            write_reg(lspbe_pkg::REG_BRIGHTNESS, {24'd0, level});
            write_reg(lspbe_pkg::REG_ENABLED, {31'd0, on});
            write_reg(lspbe_pkg::REG_PIXEL_COUNT, {23'd0, count});
            write_reg(lspbe_pkg::REG_ONE_CODE, {16'd0, code_one});
            write_reg(lspbe_pkg::REG_ZERO_CODE, {16'd0, code_zero});
            cur_count = int'(count);

            n = 0;
            while (n < 40) begin
                sel  = $urandom_range(0, 99);
                item = make_item(lspbe_pkg::FUNC_SEND, pick_index(cur_count), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                if (sel < 30) begin
                    // Set a pixel and often send it straight away.
                    item.func = lspbe_pkg::FUNC_SET;
                    push_item(item);
                    n++;
                    if ($urandom_range(0, 1) == 1) begin
                        item.func = lspbe_pkg::FUNC_SEND;
                        push_item(item);
                        n++;
                    end
                end else begin
                    if (sel < 55) begin
                        item.func = lspbe_pkg::FUNC_SEND;
                    end else if (sel < 65) begin
                        item.func = lspbe_pkg::FUNC_BLANK;
                    end else if (sel < 69) begin
                        item.func = lspbe_pkg::FUNC_CLEAR;
                    end else if (sel < 82) begin
                        item.func = lspbe_pkg::FUNC_END;
                    end else if (sel < 88) begin
                        item.func = FUNC_SPARE_A + 3'($urandom_range(0, 2));
                    end else begin
                        item.func        = lspbe_pkg::FUNC_SEND;
                        item.pixel_index = 8'($urandom_range(0, 255));
                    end
                    push_item(item);
                    n++;
                end
                // Now and then hold off until every code is out.
                if (p != 5 && $urandom_range(0, 39) == 0) begin
                    settle();
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lspbe_pkg.sv
rtl/lspbe_cfg.sv
rtl/lspbe_store.sv
rtl/lspbe_ser.sv
rtl/led_strip_pixel_bit_encoder.sv
verif/pixel_code_monitor.sv
verif/tb.sv
